// ----- sv/rist_pkg.sv -----
package rist_pkg;

	// default sizes
	localparam int MAX_TILES_DEF = 64;
	localparam int ID_BITS_DEF   = 16;
	localparam int RING_LEN      = 4;
	localparam int LANE_BITS     = 16;
	localparam int POS_BITS      = 16;

	// command codes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_MATCH  = 2'd2,
		OP_FIND   = 2'd3
	} opcode_t;

	// result codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_AMBIGUOUS = 3'd2,
		ST_SYMMETRIC = 3'd3,
		ST_DUPLICATE = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	// request word
	typedef struct packed {
		opcode_t               opcode;
		logic [7:0]            grid_row;
		logic [7:0]            grid_col;
		logic [LANE_BITS-1:0]  marker_id_a;
		logic [LANE_BITS-1:0]  marker_id_b;
		logic [LANE_BITS-1:0]  marker_id_c;
		logic [LANE_BITS-1:0]  marker_id_d;
	} req_t;

	// response word
	typedef struct packed {
		status_t    status;
		logic [5:0] slot;
		logic [1:0] rotation;
		logic [7:0] found_row;
		logic [7:0] found_col;
	} rsp_t;

	// compare result for one stored entry
	typedef struct packed {
		logic [RING_LEN-1:0] fit;
		logic                hit;
		logic                multi;
		logic [1:0]          rot;
		logic                pos_eq;
	} cmp_t;

endpackage

// ----- sv/rotation_invariant_signature_table.sv -----
// channel  | valid      | stall      | word
// request  | req_valid  | req_stall  | req  (rist_pkg::req_t)
// response | rsp_valid  | rsp_stall  | rsp  (rist_pkg::rsp_t)
//
// one request at a time; insert, match and find walk the stored tiles through
// the single read port of the tile memory, one entry per cycle. the response
// word is built in S_FINAL once the scan has drained through S_DRAIN (an
// empty table skips the scan; clear or a symmetric ring go straight to
// S_DONE), and the request side reopens when S_DONE passes the word to the
// response register. that register lets the next request be accepted while a
// response still waits; that request then holds in its last state until the
// register frees. reset empties the table; the memory itself is not cleared,
// entries at or above the tile count are never read.
module rotation_invariant_signature_table #(
	parameter int MAX_TILES = rist_pkg::MAX_TILES_DEF,
	parameter int ID_BITS   = rist_pkg::ID_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rist_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rist_pkg::rsp_t rsp
);

	localparam int IDX_W  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int CNT_W  = $clog2(MAX_TILES + 1);
	localparam int RING_W = rist_pkg::RING_LEN * ID_BITS;
	localparam int MEM_W  = RING_W + rist_pkg::POS_BITS;

	typedef logic [rist_pkg::RING_LEN-1:0][ID_BITS-1:0] ring_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINAL,
		S_DONE
	} state_t;

	state_t                        state_q;
	rist_pkg::opcode_t             op_q;
	logic [7:0]                    row_q;
	logic [7:0]                    col_q;
	ring_t                         obs_q;
	logic [IDX_W-1:0]              idx_q;
	logic [CNT_W-1:0]              count_q;
	logic                          hit_q;
	logic                          multi_q;
	logic [IDX_W-1:0]              hit_slot_q;
	logic [1:0]                    hit_rot_q;
	logic [rist_pkg::POS_BITS-1:0] hit_pos_q;
	rist_pkg::rsp_t                res_q;
	rist_pkg::rsp_t                rsp_q;
	logic                          rsp_valid_q;
	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              slot_s1;

	logic                          req_acc;
	logic                          rsp_free;
	logic                          rsp_load;
	ring_t                         obs_in;
	rist_pkg::cmp_t                sym_res;
	rist_pkg::cmp_t                ent_res;
	logic                          rd_en;
	logic                          wr_en;
	logic [MEM_W-1:0]              wr_data;
	logic [MEM_W-1:0]              rd_data;
	ring_t                         rd_ring;
	logic [rist_pkg::POS_BITS-1:0] rd_pos;
	logic [CNT_W-1:0]              last_idx;
	logic                          full;

	// build one response word
	function automatic rist_pkg::rsp_t pack_rsp(
		rist_pkg::status_t st,
		logic [5:0]        slot,
		logic [1:0]        rot,
		logic [7:0]        row,
		logic [7:0]        col
	);
		rist_pkg::rsp_t w;
		w.status    = st;
		w.slot      = slot;
		w.rotation  = rot;
		w.found_row = row;
		w.found_col = col;
		return w;
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == S_DONE) && rsp_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// observed ring, masked to the id width
	assign obs_in[0] = req.marker_id_a[ID_BITS-1:0];
	assign obs_in[1] = req.marker_id_b[ID_BITS-1:0];
	assign obs_in[2] = req.marker_id_c[ID_BITS-1:0];
	assign obs_in[3] = req.marker_id_d[ID_BITS-1:0];

	// self rotation check on the incoming ring
	rist_cmp #(.ID_BITS(ID_BITS)) u_sym (
		.obs    (obs_in),
		.stored (obs_in),
		.row    (req.grid_row),
		.col    (req.grid_col),
		.pos    ({req.grid_row, req.grid_col}),
		.res    (sym_res)
	);

	// tile memory: position above ring
	assign rd_en    = (state_q == S_SCAN);
	assign last_idx = count_q - CNT_W'(1);
	assign full     = (count_q >= CNT_W'(MAX_TILES));
	assign wr_en    = (state_q == S_FINAL) && (op_q == rist_pkg::OP_INSERT) && !hit_q && !full;
	assign wr_data  = {row_q, col_q, obs_q};

	rist_mem #(.WIDTH(MEM_W), .DEPTH(MAX_TILES), .AW(IDX_W)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign rd_ring = rd_data[RING_W-1:0];
	assign rd_pos  = rd_data[MEM_W-1:RING_W];

	// stored entry against the held request
	rist_cmp #(.ID_BITS(ID_BITS)) u_ent (
		.obs    (obs_q),
		.stored (rd_ring),
		.row    (row_q),
		.col    (col_q),
		.pos    (rd_pos),
		.res    (ent_res)
	);

	// read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			slot_s1   <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			slot_s1   <= idx_q;
		end
	end

	// sequencer, hit tracking and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= rist_pkg::OP_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			obs_q       <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			hit_q       <= 1'b0;
			multi_q     <= 1'b0;
			hit_slot_q  <= '0;
			hit_rot_q   <= '0;
			hit_pos_q   <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// response register: load the finished word, empty when taken
			if (rsp_load) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// fold one stored entry into the running hit state
			if (rd_vld_s1) begin
				unique case (op_q)
					rist_pkg::OP_MATCH: begin
						if (ent_res.hit) begin
							if (hit_q || ent_res.multi) begin
								multi_q <= 1'b1;
							end
							if (!hit_q) begin
								hit_q      <= 1'b1;
								hit_slot_q <= slot_s1;
								hit_rot_q  <= ent_res.rot;
								hit_pos_q  <= rd_pos;
							end
						end
					end
					rist_pkg::OP_INSERT: begin
						if (ent_res.hit) begin
							hit_q <= 1'b1;
						end
					end
					rist_pkg::OP_FIND: begin
						if (ent_res.pos_eq && !hit_q) begin
							hit_q      <= 1'b1;
							hit_slot_q <= slot_s1;
							hit_pos_q  <= rd_pos;
						end
					end
					default: begin
					end
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						op_q    <= req.opcode;
						row_q   <= req.grid_row;
						col_q   <= req.grid_col;
						obs_q   <= obs_in;
						idx_q   <= '0;
						hit_q   <= 1'b0;
						multi_q <= 1'b0;
						priority if (req.opcode == rist_pkg::OP_CLEAR) begin
							count_q <= '0;
							res_q   <= pack_rsp(rist_pkg::ST_OK, '0, '0, '0, '0);
							state_q <= S_DONE;
						end else if (req.opcode == rist_pkg::OP_INSERT &&
						             |sym_res.fit[rist_pkg::RING_LEN-1:1]) begin
							res_q   <= pack_rsp(rist_pkg::ST_SYMMETRIC, '0, '0, '0, '0);
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							state_q <= S_FINAL;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (CNT_W'(idx_q) == last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					state_q <= S_DONE;
					unique case (op_q)
						rist_pkg::OP_MATCH: begin
							priority if (multi_q) begin
								res_q <= pack_rsp(rist_pkg::ST_AMBIGUOUS, '0, '0, '0, '0);
							end else if (hit_q) begin
								res_q <= pack_rsp(rist_pkg::ST_OK, 6'(hit_slot_q), hit_rot_q,
									hit_pos_q[15:8], hit_pos_q[7:0]);
							end else begin
								res_q <= pack_rsp(rist_pkg::ST_NOT_FOUND, '0, '0, '0, '0);
							end
						end
						rist_pkg::OP_FIND: begin
							if (hit_q) begin
								res_q <= pack_rsp(rist_pkg::ST_OK, 6'(hit_slot_q), '0,
									row_q, col_q);
							end else begin
								res_q <= pack_rsp(rist_pkg::ST_NOT_FOUND, '0, '0, '0, '0);
							end
						end
						rist_pkg::OP_INSERT: begin
							priority if (hit_q) begin
								res_q <= pack_rsp(rist_pkg::ST_DUPLICATE, '0, '0, '0, '0);
							end else if (full) begin
								res_q <= pack_rsp(rist_pkg::ST_FULL, '0, '0, '0, '0);
							end else begin
								res_q   <= pack_rsp(rist_pkg::ST_OK, 6'(count_q), '0,
									row_q, col_q);
								count_q <= count_q + CNT_W'(1);
							end
						end
						default: begin
							res_q <= pack_rsp(rist_pkg::ST_OK, '0, '0, '0, '0);
						end
					endcase
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/rist_mem.sv -----
module rist_mem #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/rist_cmp.sv -----
module rist_cmp #(
	parameter int ID_BITS = rist_pkg::ID_BITS_DEF
) (
	input  logic [rist_pkg::RING_LEN-1:0][ID_BITS-1:0] obs,
	input  logic [rist_pkg::RING_LEN-1:0][ID_BITS-1:0] stored,
	input  logic [7:0]                                 row,
	input  logic [7:0]                                 col,
	input  logic [rist_pkg::POS_BITS-1:0]              pos,
	output rist_pkg::cmp_t                             res
);

	logic [rist_pkg::RING_LEN-1:0] fit;

	// observed lane k against stored lane (k+r) mod 4, all rotations at once
	always_comb begin
		for (int r = 0; r < rist_pkg::RING_LEN; r++) begin
			fit[r] = 1'b1;
			for (int k = 0; k < rist_pkg::RING_LEN; k++) begin
				if (obs[k] != stored[(k + r) % rist_pkg::RING_LEN]) begin
					fit[r] = 1'b0;
				end
			end
		end
	end

	// lowest fitting rotation, any fit and more than one fit
	always_comb begin
		res.fit    = fit;
		res.hit    = |fit;
		res.multi  = ($countones(fit) > 1);
		res.pos_eq = (pos == {row, col});
		priority if (fit[0]) begin
			res.rot = 2'd0;
		end else if (fit[1]) begin
			res.rot = 2'd1;
		end else if (fit[2]) begin
			res.rot = 2'd2;
		end else begin
			res.rot = 2'd3;
		end
	end

endmodule

// ----- sv/rist_chk.sv -----
module rist_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input rist_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input rist_pkg::rsp_t rsp
);

	// a waiting response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// its word does not change while stalled
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("response word changed while stalled");

	// one request in flight: accept closes the request side
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	// failed requests carry no slot, rotation or position
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != rist_pkg::ST_OK |->
			rsp.slot == '0 && rsp.rotation == '0 &&
			rsp.found_row == '0 && rsp.found_col == '0)
		else $error("nonzero fields on a failed response");

endmodule

bind rotation_invariant_signature_table rist_chk u_rist_chk (.*);

// ----- bench/tb_rotation_invariant_signature_table.sv -----
module tb_rotation_invariant_signature_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned RANDOM_WORDS = 600;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam logic [15:0] ID_MASK = 16'((32'd1 << rist_pkg::ID_BITS_DEF) - 1);

	// tile table predictor and queue of expected response words
	class tile_scoreboard;
		logic [63:0] ring_mem [rist_pkg::MAX_TILES_DEF];
		logic [15:0] pos_mem [rist_pkg::MAX_TILES_DEF];
		int unsigned tile_cnt = 0;
		rist_pkg::rsp_t pending_rsp [$];
		int unsigned errors = 0;
		int unsigned rsp_cnt = 0;

		// lane k of the result is lane (k+r) mod 4 of the ring
		static function logic [63:0] rotate_ring(logic [63:0] ring, int unsigned r);
			logic [63:0] out;
			int k;
			for (k = 0; k < rist_pkg::RING_LEN; k++) begin
				out[rist_pkg::LANE_BITS*k +: rist_pkg::LANE_BITS] =
					ring[rist_pkg::LANE_BITS*((k + r) % rist_pkg::RING_LEN)
						+: rist_pkg::LANE_BITS];
			end
			return out;
		endfunction

		// accepted request: update the table and queue its response
		function void note(rist_pkg::req_t w);
			logic [63:0] obs;
			rist_pkg::rsp_t res;
			int unsigned hits;
			bit hit;
			int t;
			int r;
			obs = {w.marker_id_d, w.marker_id_c, w.marker_id_b, w.marker_id_a}
				& {rist_pkg::RING_LEN{ID_MASK}};
			res = '0;
			res.status = rist_pkg::ST_OK;
			hit = 1'b0;
			hits = 0;
			unique case (w.opcode)
				rist_pkg::OP_CLEAR: begin
					tile_cnt = 0;
				end
				rist_pkg::OP_INSERT: begin
					// symmetric beats duplicate beats full
					for (t = 0; t < tile_cnt; t++) begin
						for (r = 0; r < rist_pkg::RING_LEN; r++) begin
							if (obs == rotate_ring(ring_mem[t], r))
								hit = 1'b1;
						end
					end
					if (obs == rotate_ring(obs, 1) || obs == rotate_ring(obs, 2)
						|| obs == rotate_ring(obs, 3)) begin
						res.status = rist_pkg::ST_SYMMETRIC;
					end else if (hit) begin
						res.status = rist_pkg::ST_DUPLICATE;
					end else if (tile_cnt >= rist_pkg::MAX_TILES_DEF) begin
						res.status = rist_pkg::ST_FULL;
					end else begin
						ring_mem[tile_cnt] = obs;
						pos_mem[tile_cnt] = {w.grid_row, w.grid_col};
						res.slot = 6'(tile_cnt);
						res.found_row = w.grid_row;
						res.found_col = w.grid_col;
						tile_cnt++;
					end
				end
				rist_pkg::OP_MATCH: begin
					for (t = 0; t < tile_cnt; t++) begin
						for (r = 0; r < rist_pkg::RING_LEN; r++) begin
							if (obs == rotate_ring(ring_mem[t], r)) begin
								hits++;
								if (hits == 1) begin
									res.slot = 6'(t);
									res.rotation = 2'(r);
									{res.found_row, res.found_col} = pos_mem[t];
								end
							end
						end
					end
					if (hits != 1) begin
						res = '0;
						res.status = (hits == 0) ? rist_pkg::ST_NOT_FOUND
							: rist_pkg::ST_AMBIGUOUS;
					end
				end
				rist_pkg::OP_FIND: begin
					// lowest slot at this position wins
					for (t = 0; t < tile_cnt; t++) begin
						if (!hit && pos_mem[t] == {w.grid_row, w.grid_col}) begin
							hit = 1'b1;
							res.slot = 6'(t);
							res.found_row = w.grid_row;
							res.found_col = w.grid_col;
						end
					end
					if (!hit)
						res.status = rist_pkg::ST_NOT_FOUND;
				end
			endcase
			pending_rsp = {pending_rsp, res};
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// accepted response against the oldest expectation
		task check(rist_pkg::rsp_t got);
			rist_pkg::rsp_t want;
			rsp_cnt++;
			if (pending_rsp.size() == 0) begin
				report($sformatf("response %0d: no word expected, status %0d",
					rsp_cnt, got.status));
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status)
				report($sformatf("response %0d: status %0d, want %0d",
					rsp_cnt, got.status, want.status));
			if (got.slot !== want.slot)
				report($sformatf("response %0d: slot %0d, want %0d",
					rsp_cnt, got.slot, want.slot));
			if (got.rotation !== want.rotation)
				report($sformatf("response %0d: rotation %0d, want %0d",
					rsp_cnt, got.rotation, want.rotation));
			if (got.found_row !== want.found_row)
				report($sformatf("response %0d: found_row %0d, want %0d",
					rsp_cnt, got.found_row, want.found_row));
			if (got.found_col !== want.found_col)
				report($sformatf("response %0d: found_col %0d, want %0d",
					rsp_cnt, got.found_col, want.found_col));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	rist_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rist_pkg::rsp_t rsp;

	tile_scoreboard sb;
	bit send_calm = 1'b0;
	bit rsp_calm = 1'b0;
	int unsigned calm_left = 300;
	int unsigned stall_left = 0;
	int unsigned stall_run;
	int unsigned cycle_cnt = 0;
	int unsigned sent = 0;

	rotation_invariant_signature_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// idle length: mostly short, a few long
	function automatic int unsigned pick_gap(bit calm);
		int unsigned p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// response stall, with calm stretches
	always @(posedge clk) begin
		if (calm_left == 0) begin
			rsp_calm = !rsp_calm;
			calm_left = $urandom_range(100, 800);
		end else begin
			calm_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			stall_run = pick_gap(rsp_calm);
			rsp_stall <= (stall_run != 0);
			stall_left = (stall_run != 0) ? stall_run - 1 : 0;
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check(rsp);
	end

	function automatic rist_pkg::req_t word(rist_pkg::opcode_t op, logic [7:0] row,
		logic [7:0] col, logic [63:0] ring);
		rist_pkg::req_t w;
		w.opcode = op;
		w.grid_row = row;
		w.grid_col = col;
		{w.marker_id_d, w.marker_id_c, w.marker_id_b, w.marker_id_a} = ring;
		return w;
	endfunction

	function automatic rist_pkg::req_t random_word();
		rist_pkg::req_t w;
		w.opcode = rist_pkg::opcode_t'($urandom_range(0, 3));
		w.grid_row = 8'($urandom);
		w.grid_col = 8'($urandom);
		w.marker_id_a = 16'($urandom);
		w.marker_id_b = 16'($urandom);
		w.marker_id_c = 16'($urandom);
		w.marker_id_d = 16'($urandom);
		return w;
	endfunction

	// mostly well-formed traffic built from what the table holds
	function automatic rist_pkg::req_t mixed_word();
		rist_pkg::req_t w;
		logic [63:0] ring;
		logic [15:0] x;
		logic [15:0] y;
		int unsigned n;
		int unsigned t;
		int unsigned sel;
		int unsigned lane;
		w = random_word();
		n = sb.tile_cnt;
		t = (n != 0) ? $urandom_range(0, n - 1) : 0;
		ring = tile_scoreboard::rotate_ring(sb.ring_mem[t], $urandom_range(0, 3));
		sel = $urandom_range(0, 99);
		// crowd positions so finds see several tiles in one place
		if ($urandom_range(0, 1) == 0) begin
			w.grid_row = 8'($urandom_range(0, 3));
			w.grid_col = 8'($urandom_range(0, 3));
		end
		if (sel < 40) begin
			w.opcode = rist_pkg::OP_INSERT;
		end else if (n != 0 && sel < 62) begin
			w.opcode = rist_pkg::OP_MATCH;
			{w.marker_id_d, w.marker_id_c, w.marker_id_b, w.marker_id_a} = ring;
		end else if (n != 0 && sel < 72) begin
			w.opcode = rist_pkg::OP_FIND;
			{w.grid_row, w.grid_col} = sb.pos_mem[t];
		end else if (n != 0 && sel < 78) begin
			w.opcode = rist_pkg::OP_INSERT;
			{w.marker_id_d, w.marker_id_c, w.marker_id_b, w.marker_id_a} = ring;
		end else if (sel < 84) begin
			// ring that repeats under a half or quarter turn
			x = 16'($urandom);
			y = ($urandom_range(0, 1) == 0) ? x : 16'($urandom);
			w.opcode = rist_pkg::OP_INSERT;
			{w.marker_id_d, w.marker_id_c, w.marker_id_b, w.marker_id_a} = {y, x, y, x};
		end else if (n != 0 && sel < 90) begin
			// near miss: one lane off
			lane = $urandom_range(0, 3);
			ring[rist_pkg::LANE_BITS*lane +: rist_pkg::LANE_BITS] ^=
				16'($urandom_range(1, 65535));
			w.opcode = rist_pkg::OP_MATCH;
			{w.marker_id_d, w.marker_id_c, w.marker_id_b, w.marker_id_a} = ring;
		end else begin
			w.opcode = rist_pkg::opcode_t'($urandom_range(1, 3));
		end
		return w;
	endfunction

	// present one word, hold it through stall, then maybe idle
	task automatic send_word(input rist_pkg::req_t w);
		int unsigned gap;
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note(w);
		sent++;
		gap = pick_gap(send_calm);
		if (gap != 0) begin
			req_valid <= 1'b0;
			req <= random_word();
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every response is back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_rsp.size() != 0);
	endtask

	initial begin
		logic [63:0] ring_a;
		logic [63:0] ring_b;
		rist_pkg::req_t w;
		int r;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		arst_n = 1'b0;
		sb = new();
		ring_a = {16'd4, 16'd3, 16'd2, 16'd1};
		ring_b = {16'h8000, 16'h0000, 16'hFFFE, 16'hFFFF};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_word(word(rist_pkg::OP_FIND, 8'd0, 8'd0, '0));
		send_word(word(rist_pkg::OP_MATCH, 8'd0, 8'd0, ring_a));
		// symmetric rings: all lanes equal, then a half-turn repeat
		send_word(word(rist_pkg::OP_INSERT, 8'd9, 8'd9, '0));
		send_word(word(rist_pkg::OP_INSERT, 8'd9, 8'd9,
			{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}));
		// fill a few slots, one rotation of a stored ring gets rejected
		send_word(word(rist_pkg::OP_INSERT, 8'd0, 8'd0, ring_a));
		send_word(word(rist_pkg::OP_INSERT, 8'd255, 8'd255, ring_b));
		send_word(word(rist_pkg::OP_INSERT, 8'd7, 8'd7,
			tile_scoreboard::rotate_ring(ring_a, 1)));
		send_word(word(rist_pkg::OP_INSERT, 8'd0, 8'd0, {16'd7, 16'd5, 16'd6, 16'd5}));
		// every rotation of a stored ring
		for (r = 0; r < rist_pkg::RING_LEN; r++)
			send_word(word(rist_pkg::OP_MATCH, 8'd0, 8'd0,
				tile_scoreboard::rotate_ring(ring_a, r)));
		send_word(word(rist_pkg::OP_MATCH, 8'd0, 8'd0,
			tile_scoreboard::rotate_ring(ring_b, 2)));
		send_word(word(rist_pkg::OP_MATCH, 8'd0, 8'd0, {16'd3, 16'd4, 16'd2, 16'd1}));
		// lowest slot at a shared position, far corner, miss
		send_word(word(rist_pkg::OP_FIND, 8'd0, 8'd0, '0));
		send_word(word(rist_pkg::OP_FIND, 8'd255, 8'd255, ring_b));
		send_word(word(rist_pkg::OP_FIND, 8'd1, 8'd0, '0));
		// clear, then the table is empty again
		send_word(word(rist_pkg::OP_CLEAR, 8'd255, 8'd255, ring_b));
		send_word(word(rist_pkg::OP_MATCH, 8'd0, 8'd0, ring_a));
		send_word(word(rist_pkg::OP_FIND, 8'd0, 8'd0, '0));
		send_word(word(rist_pkg::OP_INSERT, 8'd0, 8'd0, ring_a));
		drain();

		// random episodes, each starting from an empty table
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			send_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				drain();
			w = random_word();
			w.opcode = rist_pkg::OP_CLEAR;
			send_word(w);
			if ($urandom_range(0, 3) == 0) begin
				// fill the table, then keep pushing past its end
				repeat (rist_pkg::MAX_TILES_DEF) begin
					w = random_word();
					w.opcode = rist_pkg::OP_INSERT;
					send_word(w);
				end
				repeat ($urandom_range(8, 20))
					send_word(mixed_word());
			end else begin
				repeat ($urandom_range(10, 50))
					send_word(mixed_word());
			end
		end
		req_valid <= 1'b0;

		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
